[rtl/btp_pkg.sv]
// Shared types and codes for the bitplane tile to pixel converter.
`default_nettype none

package btp_pkg;

   // Command codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   // Tile formats
   localparam logic [1:0] FMT_PLANES2 = 2'd0;
   localparam logic [1:0] FMT_PLANES4 = 2'd1;
   localparam logic [1:0] FMT_BYTE    = 2'd2;
   localparam logic [1:0] FMT_UNUSED  = 2'd3;

   // Entries in the command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic        operation;
      logic [6:0]  byte_index;
      logic [7:0]  byte_value;
      logic [1:0]  tile_format;
      logic [7:0]  surface_id;
      logic [14:0] origin_x;
      logic [14:0] origin_y;
      logic [4:0]  zoom_factor;
      logic        palette_wanted;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

`default_nettype wire

[rtl/bitplane_tile_to_pixels_unit.sv]
// Top level of the bitplane tile to pixel converter.
//
//   channel | ports                      | transfer
//   --------+----------------------------+--------------------------------
//   request | start, busy, req_*         | edge with start high, busy low
//   result  | rsp_valid, rsp_*           | every edge with rsp_valid high
//
// A load writes the tile store as the back end dequeues it. A draw is dequeued, then per row
// fetches the plane bytes through the single tile store read port (2, 4 or 8 reads,
// one for the unused format), passes a drain state and emits the row's 8 pixels.
// A two-entry queue takes requests while a draw runs; busy is high while it is full.
// Synchronous reset empties the queue and clears the store's valid bits.
`default_nettype none

module bitplane_tile_to_pixels_unit
   import btp_pkg::*;
#(
   parameter int TILE_STORE_BYTES = 128
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_operation,
   input  wire logic [6:0]  req_byte_index,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic [1:0]  req_tile_format,
   input  wire logic [7:0]  req_surface_id,
   input  wire logic signed [14:0] req_origin_x,
   input  wire logic signed [14:0] req_origin_y,
   input  wire logic [4:0]  req_zoom_factor,
   input  wire logic        req_palette_wanted,
   output logic             rsp_valid,
   output logic [7:0]       rsp_surface_out,
   output logic signed [15:0] rsp_pixel_x,
   output logic signed [15:0] rsp_pixel_y,
   output logic [4:0]       rsp_block_size,
   output logic [7:0]       rsp_color_index,
   output logic             rsp_palette_flag,
   output logic             rsp_last_pixel
);

   qstat_type q_stat;
   logic      push;
   cmd_type   push_data;
   logic      pop;
   cmd_type   head;

   btp_front #(.TILE_STORE_BYTES(TILE_STORE_BYTES)) u_front (
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_byte_index     (req_byte_index),
      .req_byte_value     (req_byte_value),
      .req_tile_format    (req_tile_format),
      .req_surface_id     (req_surface_id),
      .req_origin_x       (req_origin_x),
      .req_origin_y       (req_origin_y),
      .req_zoom_factor    (req_zoom_factor),
      .req_palette_wanted (req_palette_wanted),
      .q_stat             (q_stat),
      .push               (push),
      .push_data          (push_data)
   );

   btp_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (head),
      .q_stat    (q_stat)
   );

   btp_back #(.TILE_STORE_BYTES(TILE_STORE_BYTES)) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_stat           (q_stat),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_surface_out  (rsp_surface_out),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_block_size   (rsp_block_size),
      .rsp_color_index  (rsp_color_index),
      .rsp_palette_flag (rsp_palette_flag),
      .rsp_last_pixel   (rsp_last_pixel)
   );

endmodule

`default_nettype wire

[rtl/btp_fifo.sv]
// Two-entry command queue that decouples the front from the back.
`default_nettype none

module btp_fifo
   import btp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire cmd_type   push_data,
   input  wire logic      pop,
   output cmd_type        pop_data,
   output qstat_type      q_stat
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type         entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff,  count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CW'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

endmodule

`default_nettype wire

[rtl/btp_front.sv]
// Command front: accepts requests, drops out-of-range loads, packs queue entries.
`default_nettype none

module btp_front
   import btp_pkg::*;
#(
   parameter int TILE_STORE_BYTES = 128
)
(
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_operation,
   input  wire logic [6:0]  req_byte_index,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic [1:0]  req_tile_format,
   input  wire logic [7:0]  req_surface_id,
   input  wire logic signed [14:0] req_origin_x,
   input  wire logic signed [14:0] req_origin_y,
   input  wire logic [4:0]  req_zoom_factor,
   input  wire logic        req_palette_wanted,
   input  wire qstat_type   q_stat,
   output logic             push,
   output cmd_type          push_data
);

   logic accept;
   logic in_range;

   assign busy     = q_stat.full;
   assign accept   = start && !q_stat.full;
   assign in_range = ({1'b0, req_byte_index} < 8'(TILE_STORE_BYTES));

   // A load past the end of the store has no effect: never queue it
   assign push = accept && ((req_operation == OP_DRAW) || in_range);

   assign push_data.operation      = req_operation;
   assign push_data.byte_index     = req_byte_index;
   assign push_data.byte_value     = req_byte_value;
   assign push_data.tile_format    = req_tile_format;
   assign push_data.surface_id     = req_surface_id;
   assign push_data.origin_x       = req_origin_x;
   assign push_data.origin_y       = req_origin_y;
   assign push_data.zoom_factor    = req_zoom_factor;
   assign push_data.palette_wanted = req_palette_wanted;

endmodule

`default_nettype wire

[rtl/btp_back.sv]
// Command back: tile store, row fetch sequencer and pixel result registers.
`default_nettype none

module btp_back
   import btp_pkg::*;
#(
   parameter int TILE_STORE_BYTES = 128
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire qstat_type   q_stat,
   input  wire cmd_type     head,
   output logic             pop,
   output logic             rsp_valid,
   output logic [7:0]       rsp_surface_out,
   output logic signed [15:0] rsp_pixel_x,
   output logic signed [15:0] rsp_pixel_y,
   output logic [4:0]       rsp_block_size,
   output logic [7:0]       rsp_color_index,
   output logic             rsp_palette_flag,
   output logic             rsp_last_pixel
);

   localparam int AW = $clog2(TILE_STORE_BYTES);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   // Last fetch slot of a row for each format
   function automatic logic [2:0] last_slot(input logic [1:0] fmt);
      logic [2:0] s;
      unique case (fmt)
         FMT_PLANES2: s = 3'd1;
         FMT_PLANES4: s = 3'd3;
         FMT_BYTE:    s = 3'd7;
         default:     s = 3'd0;
      endcase
      return s;
   endfunction

   // Store position of fetch slot: plane slot for planar rows, column for byte rows
   function automatic logic [6:0] fetch_pos(input logic [1:0] fmt, input logic [2:0] row,
                                            input logic [2:0] slot);
      logic [6:0] p;
      if (fmt == FMT_BYTE) begin
         p = {row, slot, 1'b1};
      end else begin
         p = {2'b00, slot[1], row, slot[0]};
      end
      return p;
   endfunction

   logic [7:0]                 mem [TILE_STORE_BYTES];
   logic [TILE_STORE_BYTES-1:0] vld_ff;

   logic [1:0]  state_ff, state_in;
   cmd_type     cmd_ff, cmd_in;
   logic [2:0]  row_ff, row_in;
   logic [2:0]  col_ff, col_in;
   logic [2:0]  slot_ff, slot_in;
   logic [15:0] x_ff, x_in;
   logic [15:0] y_ff, y_in;

   logic        cap_vld_ff;
   logic [2:0]  cap_slot_ff;
   logic [7:0]  rd_data_ff;
   logic        rd_ok_ff;
   logic [7:0][7:0] pix_buf_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  surface_ff;
   logic [15:0] px_ff, py_ff;
   logic [4:0]  size_ff;
   logic [7:0]  color_ff, color_in;
   logic        pal_ff;
   logic        last_ff;

   logic        wr_en;
   logic [AW-1:0] wr_idx;
   logic        rd_en;
   logic [6:0]  rd_pos;
   logic        rd_in_range;
   logic [AW-1:0] rd_idx;
   logic [2:0]  bit_sel;
   logic [15:0] zoom_ext;

   assign pop    = (state_ff == ST_IDLE) && !q_stat.empty;
   assign wr_en  = pop && (head.operation == OP_LOAD);
   assign wr_idx = head.byte_index[AW-1:0];

   assign rd_en       = (state_ff == ST_FETCH);
   assign rd_pos      = fetch_pos(cmd_ff.tile_format, row_ff, slot_ff);
   assign rd_in_range = ({1'b0, rd_pos} < 8'(TILE_STORE_BYTES));
   assign rd_idx      = rd_pos[AW-1:0];

   assign zoom_ext = {11'b0, cmd_ff.zoom_factor};
   assign bit_sel  = 3'd7 - col_ff;

   // Pixel from the fetched row: leftmost pixel is the plane byte MSB
   always_comb begin
      case (cmd_ff.tile_format)
         FMT_PLANES2: color_in = {6'b0, pix_buf_ff[1][bit_sel], pix_buf_ff[0][bit_sel]};
         FMT_PLANES4: color_in = {4'b0, pix_buf_ff[3][bit_sel], pix_buf_ff[2][bit_sel],
                                  pix_buf_ff[1][bit_sel], pix_buf_ff[0][bit_sel]};
         FMT_BYTE:    color_in = pix_buf_ff[col_ff];
         default:     color_in = 8'h00;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      slot_in      = slot_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop && (head.operation == OP_DRAW)) begin
               cmd_in   = head;
               row_in   = '0;
               col_in   = '0;
               slot_in  = '0;
               x_in     = {head.origin_x[14], head.origin_x};
               y_in     = {head.origin_y[14], head.origin_y};
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (slot_ff == last_slot(cmd_ff.tile_format)) begin
               slot_in  = '0;
               state_in = ST_DRAIN;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // last fetched byte lands in the row buffer this cycle
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            col_in       = col_ff + 1'b1;
            x_in         = x_ff + zoom_ext;
            if (col_ff == 3'd7) begin
               x_in   = {cmd_ff.origin_x[14], cmd_ff.origin_x};
               y_in   = y_ff + zoom_ext;
               row_in = row_ff + 1'b1;
               state_in = (row_ff == 3'd7) ? ST_IDLE : ST_FETCH;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
         rd_ok_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_vld_ff   <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            vld_ff[wr_idx] <= 1'b1;
         end
         if (rd_en) begin
            rd_ok_ff <= rd_in_range && vld_ff[rd_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= head.byte_value;
      end
      if (rd_en && rd_in_range) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      slot_ff     <= slot_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      cap_slot_ff <= slot_ff;
      // never-written or out-of-range bytes read as zero
      if (cap_vld_ff) begin
         pix_buf_ff[cap_slot_ff] <= rd_ok_ff ? rd_data_ff : 8'h00;
      end
      if (rsp_valid_in) begin
         surface_ff <= cmd_ff.surface_id;
         px_ff      <= x_ff;
         py_ff      <= y_ff;
         size_ff    <= cmd_ff.zoom_factor;
         color_ff   <= color_in;
         pal_ff     <= cmd_ff.palette_wanted;
         last_ff    <= (row_ff == 3'd7) && (col_ff == 3'd7);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_surface_out  = surface_ff;
   assign rsp_pixel_x      = px_ff;
   assign rsp_pixel_y      = py_ff;
   assign rsp_block_size   = size_ff;
   assign rsp_color_index  = color_ff;
   assign rsp_palette_flag = pal_ff;
   assign rsp_last_pixel   = last_ff;

endmodule

`default_nettype wire

[rtl/btp_checker.sv]
// Port-level checks on the result stream of the tile converter, bound to the top level.
`default_nettype none

module btp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic [7:0]  rsp_surface_out,
   input wire logic signed [15:0] rsp_pixel_x,
   input wire logic signed [15:0] rsp_pixel_y,
   input wire logic [4:0]  rsp_block_size,
   input wire logic        rsp_palette_flag,
   input wire logic        rsp_last_pixel
);

   // results never appear in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result transfer right after reset");

   // back-to-back pixels belong to the same row of the same draw
   a_row_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid) |->
         $stable(rsp_surface_out) && $stable(rsp_pixel_y) &&
         $stable(rsp_block_size) && $stable(rsp_palette_flag))
      else $error("draw fields changed inside a pixel row");

   // x advances by the zoom between neighboring pixels
   a_x_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid) |->
         (16'(rsp_pixel_x - $past(rsp_pixel_x)) == {11'b0, rsp_block_size}))
      else $error("pixel x step differs from block size");

   // the last pixel ends a row, so the stream pauses after it
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_pixel |=> !rsp_valid)
      else $error("result transfer directly after last pixel");

endmodule

bind bitplane_tile_to_pixels_unit btp_checker u_btp_checker (.*);

`default_nettype wire

[tb/tb_bitplane_tile_to_pixels_unit.sv]
// Testbench for the bitplane tile to pixel converter: directed and random load/draw traffic.
`default_nettype none

module tb_bitplane_tile_to_pixels_unit;
   import btp_pkg::*;

   localparam int STORE_BYTES    = 128;
   localparam int STALL_LIMIT    = 4000;
   localparam int TAIL_CYCLES    = 300;
   localparam int RANDOM_ITEMS   = 92;

   typedef struct {
      logic [7:0]  surface;
      logic [15:0] x;
      logic [15:0] y;
      logic [4:0]  size;
      logic [7:0]  color;
      logic        palette;
      logic        last;
   } pixel_rec_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_operation;
   logic [6:0]  req_byte_index;
   logic [7:0]  req_byte_value;
   logic [1:0]  req_tile_format;
   logic [7:0]  req_surface_id;
   logic signed [14:0] req_origin_x;
   logic signed [14:0] req_origin_y;
   logic [4:0]  req_zoom_factor;
   logic        req_palette_wanted;
   logic        rsp_valid;
   logic [7:0]  rsp_surface_out;
   logic signed [15:0] rsp_pixel_x;
   logic signed [15:0] rsp_pixel_y;
   logic [4:0]  rsp_block_size;
   logic [7:0]  rsp_color_index;
   logic        rsp_palette_flag;
   logic        rsp_last_pixel;

   logic [7:0]  tile_shadow [0:STORE_BYTES-1];
   pixel_rec_type pending_pixels [$];
   int          mismatch_count = 0;
   int          stall_cycles = 0;
   bit          no_idle = 0;

   bitplane_tile_to_pixels_unit #(.TILE_STORE_BYTES(STORE_BYTES)) i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_byte_index     (req_byte_index),
      .req_byte_value     (req_byte_value),
      .req_tile_format    (req_tile_format),
      .req_surface_id     (req_surface_id),
      .req_origin_x       (req_origin_x),
      .req_origin_y       (req_origin_y),
      .req_zoom_factor    (req_zoom_factor),
      .req_palette_wanted (req_palette_wanted),
      .rsp_valid          (rsp_valid),
      .rsp_surface_out    (rsp_surface_out),
      .rsp_pixel_x        (rsp_pixel_x),
      .rsp_pixel_y        (rsp_pixel_y),
      .rsp_block_size     (rsp_block_size),
      .rsp_color_index    (rsp_color_index),
      .rsp_palette_flag   (rsp_palette_flag),
      .rsp_last_pixel     (rsp_last_pixel)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Decode one pixel of the shadow tile.
   function automatic logic [7:0] tile_color(logic [1:0] fmt, int row, int col);
      logic [7:0] value;
      int planes;
      int pos;
      value = 8'd0;
      if (fmt == FMT_BYTE) begin
         pos = 1 + (row * 8 + col) * 2;
         return (pos < STORE_BYTES) ? tile_shadow[pos] : 8'd0;
      end
      if (fmt == FMT_UNUSED) return 8'd0;
      planes = (fmt == FMT_PLANES2) ? 2 : 4;
      for (int q = 0; q < planes; q++) begin
         pos = (q % 2) + (q / 2) * 16 + row * 2;
         if (pos < STORE_BYTES && tile_shadow[pos][7 - col]) value[q] = 1'b1;
      end
      return value;
   endfunction

   task automatic queue_draw_pixels(logic [1:0] fmt, logic [7:0] sfc, logic [14:0] ox,
                                    logic [14:0] oy, logic [4:0] zoom, logic pal);
      pixel_rec_type rec;
      logic [15:0] step;
      for (int row = 0; row < 8; row++) begin
         for (int col = 0; col < 8; col++) begin
            rec.surface = sfc;
            step = 16'(col * zoom);
            rec.x = {ox[14], ox} + step;
            step = 16'(row * zoom);
            rec.y = {oy[14], oy} + step;
            rec.size = zoom;
            rec.color = tile_color(fmt, row, col);
            rec.palette = pal;
            rec.last = (row == 7 && col == 7);
            pending_pixels.push_back(rec);
         end
      end
   endtask

   // Drive one item and hold it until the transfer, then update the shadow state.
   task automatic send_item(logic op, logic [6:0] idx, logic [7:0] val, logic [1:0] fmt,
                            logic [7:0] sfc, logic [14:0] ox, logic [14:0] oy,
                            logic [4:0] zoom, logic pal);
      bit taken;
      taken = 0;
      @(negedge clock);
      start = 1'b1;
      req_operation = op;
      req_byte_index = idx;
      req_byte_value = val;
      req_tile_format = fmt;
      req_surface_id = sfc;
      req_origin_x = ox;
      req_origin_y = oy;
      req_zoom_factor = zoom;
      req_palette_wanted = pal;
      while (!taken) begin
         @(posedge clock);
         taken = !busy;
      end
      if (op == OP_LOAD) begin
         if (idx < STORE_BYTES) tile_shadow[idx] = val;
      end else begin
         queue_draw_pixels(fmt, sfc, ox, oy, zoom, pal);
      end
   endtask

   task automatic idle_gap(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Loads carry random draw fields, which the block must ignore.
   task automatic send_load(logic [6:0] idx, logic [7:0] val);
      idle_gap(pick_gap());
      send_item(OP_LOAD, idx, val, 2'($urandom), 8'($urandom), 15'($urandom),
                15'($urandom), 5'($urandom), 1'($urandom));
   endtask

   task automatic send_draw(logic [1:0] fmt, logic [7:0] sfc, logic [14:0] ox,
                            logic [14:0] oy, logic [4:0] zoom, logic pal);
      idle_gap(pick_gap());
      send_item(OP_DRAW, 7'($urandom), 8'($urandom), fmt, sfc, ox, oy, zoom, pal);
   endtask

   // Drop start so the last item is not taken again, then wait for every pixel.
   task automatic wait_drained();
      @(negedge clock);
      start = 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected 'h%0h, got 'h%0h", name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   // Compare each result strobe with the oldest predicted pixel.
   always @(posedge clock) begin
      pixel_rec_type want;
      if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            $error("result with no pixel pending: x 'h%0h y 'h%0h", rsp_pixel_x, rsp_pixel_y);
            mismatch_count++;
         end else begin
            want = pending_pixels.pop_front();
            check_field("surface_out", 16'(want.surface), 16'(rsp_surface_out));
            check_field("pixel_x", want.x, rsp_pixel_x);
            check_field("pixel_y", want.y, rsp_pixel_y);
            check_field("block_size", 16'(want.size), 16'(rsp_block_size));
            check_field("color_index", 16'(want.color), 16'(rsp_color_index));
            check_field("palette_flag", 16'(want.palette), 16'(rsp_palette_flag));
            check_field("last_pixel", 16'(want.last), 16'(rsp_last_pixel));
         end
      end
   end

   // Count cycles without any transfer on either side.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL bitplane_tile_to_pixels_unit");
            $finish;
         end
      end
   end

   task automatic test_store_extremes();
      send_load(7'd0, 8'hFF);
      send_load(7'd1, 8'h00);
      send_load(7'd16, 8'hA5);
      send_load(7'd17, 8'h5A);
      send_load(7'd3, 8'h81);
      send_load(7'd127, 8'hFF);
   endtask

   task automatic test_each_format();
      send_draw(FMT_PLANES2, 8'd1, 15'sd0, 15'sd0, 5'd1, 1'b0);
      send_draw(FMT_PLANES4, 8'd2, 15'sd100, -15'sd100, 5'd2, 1'b1);
      send_draw(FMT_BYTE, 8'd3, -15'sd5, 15'sd7, 5'd3, 1'b0);
      send_draw(FMT_UNUSED, 8'd4, 15'sd9, 15'sd9, 5'd4, 1'b1);
   endtask

   task automatic test_field_extremes();
      send_draw(FMT_PLANES4, 8'd0, -15'sd16384, -15'sd16384, 5'd0, 1'b0);
      send_draw(FMT_PLANES2, 8'd255, 15'sd16383, 15'sd16383, 5'd31, 1'b1);
      send_draw(FMT_BYTE, 8'h5A, 15'sd16383, -15'sd16384, 5'd16, 1'b1);
      send_draw(FMT_PLANES4, 8'hA5, -15'sd1, 15'sd16300, 5'd1, 1'b0);
   endtask

   // Hold the sender until every pixel is out, then send back to back.
   task automatic test_drain_pause();
      send_load(7'd2, 8'h3C);
      send_draw(FMT_PLANES2, 8'd7, 15'sd50, 15'sd60, 5'd5, 1'b1);
      wait_drained();
      no_idle = 1;
      send_load(7'd18, 8'hC3);
      send_draw(FMT_PLANES4, 8'd8, -15'sd50, -15'sd60, 5'd6, 1'b0);
      no_idle = 0;
   endtask

   task automatic test_random_traffic();
      int sent;
      int loads;
      logic [1:0] fmt;
      logic [6:0] idx;
      logic [4:0] zoom;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) < 8) begin
            // tile burst: a few loads into bytes the format reads (any byte if unused), then a draw
            fmt = ($urandom_range(0, 9) == 0) ? FMT_UNUSED : 2'($urandom_range(0, 2));
            loads = $urandom_range(1, 6);
            repeat (loads) begin
               case (fmt)
                  FMT_PLANES2: idx = 7'($urandom_range(0, 15));
                  FMT_PLANES4: idx = 7'($urandom_range(0, 31));
                  FMT_BYTE:    idx = 7'(1 + 2 * $urandom_range(0, 63));
                  default:     idx = 7'($urandom_range(0, 127));
               endcase
               send_load(idx, 8'($urandom));
            end
            zoom = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(1, 16));
            send_draw(fmt, 8'($urandom), 15'($urandom), 15'($urandom), zoom,
                      1'($urandom));
            sent += loads + 1;
         end else if ($urandom_range(0, 1) == 0) begin
            send_load(7'($urandom), 8'($urandom));
            sent++;
         end else begin
            send_draw(2'($urandom), 8'($urandom), 15'($urandom), 15'($urandom),
                      5'($urandom), 1'($urandom));
            sent++;
         end
      end
      no_idle = 0;
   endtask

   initial begin
      for (int i = 0; i < STORE_BYTES; i++) tile_shadow[i] = 8'd0;
      reset = 1'b1;
      start = 1'b0;
      req_operation = OP_LOAD;
      req_byte_index = '0;
      req_byte_value = '0;
      req_tile_format = FMT_PLANES2;
      req_surface_id = '0;
      req_origin_x = '0;
      req_origin_y = '0;
      req_zoom_factor = 5'd1;
      req_palette_wanted = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_store_extremes();
      test_each_format();
      test_field_extremes();
      test_drain_pause();
      test_random_traffic();

      @(negedge clock);
      start = 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_pixels.size() == 0) begin
         $display("PASS bitplane_tile_to_pixels_unit");
      end else begin
         $display("FAIL bitplane_tile_to_pixels_unit");
      end
      $finish;
   end

endmodule

`default_nettype wire
